// ===== rtl/core/fxa_pkg.sv =====
// Shared types and constants for the fixed-point ALU core.
// Holds the request and result transfer structs, operation and status codes.
// No dependencies.
package fxa_pkg;

	localparam int FRACTION_BITS_DEF = 8;
	localparam int WORD_BITS_DEF     = 32;
	localparam int OUT_BITS          = 32;

	typedef enum logic [3:0] {
		KIND_ADD,
		KIND_SUB,
		KIND_MUL,
		KIND_DIV,
		KIND_MIN,
		KIND_MAX,
		KIND_CMP,
		KIND_INC,
		KIND_DEC,
		KIND_INT
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_OVERFLOW,
		ST_DIV_ZERO
	} status_t;

	typedef struct packed {
		logic [3:0]                 kind;
		logic signed [OUT_BITS-1:0] operand_a;
		logic signed [OUT_BITS-1:0] operand_b;
	} request_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] result_value;
		logic                       less_flag;
		logic                       equal_flag;
		logic [1:0]                 status;
	} result_t;

endpackage

// ===== rtl/core/fixed_point_alu_core.sv =====
// Fixed-point ALU core, top level: input stage, simple ops, result pipeline.
// Throughput: one operation per cycle; busy stays low, the divider sets the depth.
// Reset clears all valid bits; payload registers are not reset.
// Depends on fxa_pkg, fxa_mul and fxa_div.
module fixed_point_alu_core #(
	parameter int FRACTION_BITS = fxa_pkg::FRACTION_BITS_DEF,
	parameter int WORD_BITS     = fxa_pkg::WORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  fxa_pkg::request_t request,
	output logic              done,
	output fxa_pkg::result_t  result
);
	import fxa_pkg::*;

	localparam int W    = WORD_BITS;
	localparam int QB   = WORD_BITS + FRACTION_BITS;
	localparam int LAST = QB + 2;
	localparam logic signed [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] ONE_W = {{(W-1){1'b0}}, 1'b1};

	typedef struct packed {
		logic [3:0]          kind;
		logic signed [W-1:0] value;
		logic [1:0]          status;
		logic                less;
		logic                equal;
	} meta_t;

	logic                vld_s1;
	logic [3:0]          kind_s1;
	logic signed [W-1:0] a_s1;
	logic signed [W-1:0] b_s1;

	// capture each transfer, keep the low word bits of the operands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= request.kind;
		a_s1    <= request.operand_a[W-1:0];
		b_s1    <= request.operand_b[W-1:0];
	end

	assign busy = 1'b0;

	logic signed [W:0]   sum;
	logic signed [W:0]   dif;
	logic [W-1:0]        mag_a;
	logic [W-1:0]        mag_b;
	logic [QB-1:0]       div_num;
	meta_t               simple;

	// compute the simple operations, the divide-by-zero status and the flags
	always_comb begin
		sum     = {a_s1[W-1], a_s1} + {b_s1[W-1], b_s1};
		dif     = {a_s1[W-1], a_s1} - {b_s1[W-1], b_s1};
		mag_a   = a_s1[W-1] ? (~a_s1 + ONE_W) : a_s1;
		mag_b   = b_s1[W-1] ? (~b_s1 + ONE_W) : b_s1;
		div_num = QB'(mag_a) << FRACTION_BITS;
		simple.kind   = kind_s1;
		simple.less   = a_s1 < b_s1;
		simple.equal  = a_s1 == b_s1;
		simple.value  = '0;
		simple.status = ST_OK;
		case (kind_s1)
			KIND_ADD: begin
				if (sum[W] != sum[W-1]) begin
					simple.value  = sum[W] ? MIN_W : MAX_W;
					simple.status = ST_OVERFLOW;
				end else begin
					simple.value = sum[W-1:0];
				end
			end
			KIND_SUB: begin
				if (dif[W] != dif[W-1]) begin
					simple.value  = dif[W] ? MIN_W : MAX_W;
					simple.status = ST_OVERFLOW;
				end else begin
					simple.value = dif[W-1:0];
				end
			end
			KIND_DIV: begin
				if (b_s1 == '0) begin
					simple.status = ST_DIV_ZERO;
				end
			end
			KIND_MIN: simple.value = (a_s1 < b_s1) ? a_s1 : b_s1;
			KIND_MAX: simple.value = (a_s1 > b_s1) ? a_s1 : b_s1;
			KIND_INC: begin
				if (a_s1 == MAX_W) begin
					simple.value  = MAX_W;
					simple.status = ST_OVERFLOW;
				end else begin
					simple.value = a_s1 + ONE_W;
				end
			end
			KIND_DEC: begin
				if (a_s1 == MIN_W) begin
					simple.value  = MIN_W;
					simple.status = ST_OVERFLOW;
				end else begin
					simple.value = a_s1 - ONE_W;
				end
			end
			KIND_INT: simple.value = a_s1 >>> FRACTION_BITS;
			default:  simple.value = '0;
		endcase
	end

	logic signed [W-1:0] mul_val_s3;
	logic                mul_ovf_s3;
	logic signed [W-1:0] div_val_s;
	logic                div_ovf_s;

	fxa_mul #(
		.WORD_BITS     (WORD_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_mul (
		.clk        (clk),
		.a          (a_s1),
		.b          (b_s1),
		.mul_val_s3 (mul_val_s3),
		.mul_ovf_s3 (mul_ovf_s3)
	);

	fxa_div #(
		.WORD_BITS     (WORD_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_div (
		.clk       (clk),
		.num       (div_num),
		.den       (mag_b),
		.neg       (a_s1[W-1] ^ b_s1[W-1]),
		.div_val_s (div_val_s),
		.div_ovf_s (div_ovf_s)
	);

	logic  vld_s  [2:LAST];
	meta_t meta_s [2:LAST];
	meta_t merged;

	// fold the multiplier result in once it leaves its last stage
	always_comb begin
		merged = meta_s[3];
		if (meta_s[3].kind == KIND_MUL) begin
			merged.value  = mul_val_s3;
			merged.status = mul_ovf_s3 ? ST_OVERFLOW : ST_OK;
		end
	end

	// advance valid bits alongside the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 2; k <= LAST; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[2] <= vld_s1;
			for (int k = 3; k <= LAST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		meta_s[2] <= simple;
		for (int k = 3; k <= LAST; k++) begin
			if (k == 4) begin
				meta_s[k] <= merged;
			end else begin
				meta_s[k] <= meta_s[k-1];
			end
		end
	end

	result_t out_nxt;
	result_t out_s;
	logic    done_s;

	// pick the divider result and widen to the port
	always_comb begin
		out_nxt.less_flag    = meta_s[LAST].less;
		out_nxt.equal_flag   = meta_s[LAST].equal;
		out_nxt.result_value = OUT_BITS'(meta_s[LAST].value);
		out_nxt.status       = meta_s[LAST].status;
		if (meta_s[LAST].kind == KIND_DIV && meta_s[LAST].status != ST_DIV_ZERO) begin
			out_nxt.result_value = OUT_BITS'(div_val_s);
			out_nxt.status       = div_ovf_s ? ST_OVERFLOW : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s <= 1'b0;
		end else begin
			done_s <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		out_s <= out_nxt;
	end

	assign done   = done_s;
	assign result = out_s;

endmodule

// ===== rtl/core/fxa_mul.sv =====
// Two-stage signed fixed-point multiplier with round half away from zero
// and saturation to the word range. Uses no package items.
module fxa_mul #(
	parameter int WORD_BITS     = 32,
	parameter int FRACTION_BITS = 8
) (
	input  logic                        clk,
	input  logic signed [WORD_BITS-1:0] a,
	input  logic signed [WORD_BITS-1:0] b,
	output logic signed [WORD_BITS-1:0] mul_val_s3,
	output logic                        mul_ovf_s3
);
	localparam int PW = 2 * WORD_BITS;
	localparam logic [PW-1:0] ONE  = {{(PW-1){1'b0}}, 1'b1};
	localparam logic [PW-1:0] HALF = (FRACTION_BITS == 0) ? '0 :
		(ONE << ((FRACTION_BITS > 0) ? FRACTION_BITS - 1 : 0));
	localparam logic [PW-1:0] LIM_POS = {{(WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
	localparam logic [PW-1:0] LIM_NEG = LIM_POS + ONE;

	logic signed [PW-1:0] prod_s2;
	logic                 neg;
	logic [PW-1:0]        mag;
	logic [PW-1:0]        rnd;
	logic [PW-1:0]        rnd_neg;
	logic signed [WORD_BITS-1:0] val;
	logic                 ovf;

	// register the full product
	always_ff @(posedge clk) begin
		prod_s2 <= PW'(a) * PW'(b);
	end

	// round the magnitude, restore sign, saturate
	always_comb begin
		neg     = prod_s2[PW-1];
		mag     = neg ? (~prod_s2 + ONE) : prod_s2;
		rnd     = (mag + HALF) >> FRACTION_BITS;
		rnd_neg = ~rnd + ONE;
		ovf     = 1'b0;
		if (!neg && rnd > LIM_POS) begin
			val = LIM_POS[WORD_BITS-1:0];
			ovf = 1'b1;
		end else if (neg && rnd > LIM_NEG) begin
			val = LIM_NEG[WORD_BITS-1:0];
			ovf = 1'b1;
		end else if (neg) begin
			val = rnd_neg[WORD_BITS-1:0];
		end else begin
			val = rnd[WORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		mul_val_s3 <= val;
		mul_ovf_s3 <= ovf;
	end

endmodule

// ===== rtl/core/fxa_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, then a rounding
// stage (half away from zero) with saturation. Uses no package items.
module fxa_div #(
	parameter int WORD_BITS     = 32,
	parameter int FRACTION_BITS = 8
) (
	input  logic                                  clk,
	input  logic [WORD_BITS+FRACTION_BITS-1:0]    num,
	input  logic [WORD_BITS-1:0]                  den,
	input  logic                                  neg,
	output logic signed [WORD_BITS-1:0]           div_val_s,
	output logic                                  div_ovf_s
);
	localparam int W  = WORD_BITS;
	localparam int QB = WORD_BITS + FRACTION_BITS;
	localparam logic [QB:0] ONE     = {{QB{1'b0}}, 1'b1};
	localparam logic [QB:0] LIM_POS = {{(QB-W+2){1'b0}}, {(W-1){1'b1}}};
	localparam logic [QB:0] LIM_NEG = LIM_POS + ONE;

	logic [W-1:0]  rem_s [QB];
	logic [QB-1:0] quo_s [QB];
	logic [QB-1:0] num_s [QB];
	logic [W-1:0]  den_s [QB];
	logic          neg_s [QB];

	logic [W-1:0]  rem_in [QB];
	logic [QB-1:0] quo_in [QB];
	logic [QB-1:0] num_in [QB];
	logic [W-1:0]  den_in [QB];
	logic          neg_in [QB];
	logic [W:0]    trial  [QB];
	logic [W:0]    diff   [QB];
	logic          ge     [QB];

	// select each stage's source: the ports for the first, the prior stage otherwise
	always_comb begin
		for (int k = 0; k < QB; k++) begin
			if (k == 0) begin
				rem_in[k] = '0;
				quo_in[k] = '0;
				num_in[k] = num;
				den_in[k] = den;
				neg_in[k] = neg;
			end else begin
				rem_in[k] = rem_s[k-1];
				quo_in[k] = quo_s[k-1];
				num_in[k] = num_s[k-1];
				den_in[k] = den_s[k-1];
				neg_in[k] = neg_s[k-1];
			end
			trial[k] = {rem_in[k], num_in[k][QB-1]};
			diff[k]  = trial[k] - {1'b0, den_in[k]};
			ge[k]    = trial[k] >= {1'b0, den_in[k]};
		end
	end

	// advance one quotient bit per stage
	always_ff @(posedge clk) begin
		for (int k = 0; k < QB; k++) begin
			rem_s[k] <= ge[k] ? diff[k][W-1:0] : trial[k][W-1:0];
			quo_s[k] <= {quo_in[k][QB-2:0], ge[k]};
			num_s[k] <= num_in[k] << 1;
			den_s[k] <= den_in[k];
			neg_s[k] <= neg_in[k];
		end
	end

	logic                  round_up;
	logic [QB:0]           q_rnd;
	logic [QB:0]           q_neg;
	logic signed [W-1:0]   val;
	logic                  ovf;

	// round on the remainder, restore sign, saturate
	always_comb begin
		round_up = {rem_s[QB-1], 1'b0} >= {1'b0, den_s[QB-1]};
		q_rnd    = {1'b0, quo_s[QB-1]} + (round_up ? ONE : '0);
		q_neg    = ~q_rnd + ONE;
		ovf      = 1'b0;
		if (!neg_s[QB-1] && q_rnd > LIM_POS) begin
			val = LIM_POS[W-1:0];
			ovf = 1'b1;
		end else if (neg_s[QB-1] && q_rnd > LIM_NEG) begin
			val = LIM_NEG[W-1:0];
			ovf = 1'b1;
		end else if (neg_s[QB-1]) begin
			val = q_neg[W-1:0];
		end else begin
			val = q_rnd[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		div_val_s <= val;
		div_ovf_s <= ovf;
	end

endmodule

// ===== rtl/core/fxa_checker.sv =====
// Port-level checker for the fixed-point ALU core and its bind statement.
// Depends on fxa_pkg and fixed_point_alu_core.
module fxa_core_assert #(
	parameter int FRACTION_BITS = fxa_pkg::FRACTION_BITS_DEF,
	parameter int WORD_BITS     = fxa_pkg::WORD_BITS_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input fxa_pkg::result_t  result
);
	import fxa_pkg::*;

	localparam int LAT = WORD_BITS + FRACTION_BITS + 3;

	// every transfer in gives one result a fixed latency later
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result missing after accepted transfer");

	// no result without a transfer in
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without matching transfer");

	// divide by zero returns zero
	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_DIV_ZERO) |-> (result.result_value == '0))
		else $error("divide by zero returned nonzero value");

	// flags are exclusive and status is a known code
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!(result.less_flag && result.equal_flag) && result.status != 2'd3))
		else $error("inconsistent flags or status");

endmodule

bind fixed_point_alu_core fxa_core_assert #(
	.FRACTION_BITS (FRACTION_BITS),
	.WORD_BITS     (WORD_BITS)
) u_fxa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
